@@ rtl/lpfp_pkg.sv @@
// Shared types for the length-prefixed frame parser.
package lpfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned SEC_W   = 3;

    typedef enum logic [SEC_W-1:0] {
        SEC_ID   = 3'd0,
        SEC_HLEN = 3'd1,
        SEC_PLEN = 3'd2,
        SEC_HDR  = 3'd3,
        SEC_PAY  = 3'd4
    } section_t;

    typedef struct packed {
        section_t             phase;
        logic [VALUE_W-1:0]   byte_count;
        logic [VALUE_W-1:0]   assembled_value;
        logic [VALUE_W-1:0]   header_length;
        logic [VALUE_W-1:0]   payload_length;
    } parse_state_t;

    typedef struct packed {
        logic [SEC_W-1:0]     section;
        logic [BYTE_W-1:0]    byte_out;
        logic                 section_last;
        logic [VALUE_W-1:0]   field_value;
        logic                 frame_end;
    } parse_result_t;

endpackage

@@ rtl/lpfp_if.sv @@
// Channel interfaces for the received byte stream and the tagged result beats.
interface lpfp_byte_if;
    logic                         valid;
    logic                         ready;
    logic [lpfp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_result_if;
    logic                         valid;
    logic                         ready;
    logic [lpfp_pkg::SEC_W-1:0]   section;
    logic [lpfp_pkg::BYTE_W-1:0]  byte_out;
    logic                         section_last;
    logic [lpfp_pkg::VALUE_W-1:0] field_value;
    logic                         frame_end;

    modport source (output valid, output section, output byte_out, output section_last,
                    output field_value, output frame_end, input ready);
    modport sink   (input valid, input section, input byte_out, input section_last,
                    input field_value, input frame_end, output ready);
endinterface

@@ rtl/lpfp_step.sv @@
// Per-byte parse step: next parser state and the tagged result for one byte.
module lpfp_step #(
    parameter int unsigned ID_BYTES  = 8,
    parameter int unsigned LEN_BYTES = 8
) (
    input  lpfp_pkg::parse_state_t  cur,
    input  logic [lpfp_pkg::BYTE_W-1:0] rx_byte,
    output lpfp_pkg::parse_state_t  nxt,
    output lpfp_pkg::parse_result_t res
);
    import lpfp_pkg::*;

    localparam logic [VALUE_W:0] ID_NEED  = (VALUE_W+1)'(ID_BYTES);
    localparam logic [VALUE_W:0] LEN_NEED = (VALUE_W+1)'(LEN_BYTES);

    section_t           sec;
    logic [VALUE_W:0]   count_inc;
    logic [VALUE_W:0]   need;
    logic               last;
    logic [VALUE_W-1:0] acc;

    always_comb
    begin
        unique case (cur.phase)
            SEC_ID, SEC_HLEN, SEC_PLEN, SEC_HDR, SEC_PAY: sec = cur.phase;
            default: sec = SEC_ID;
        endcase

        count_inc = {1'b0, cur.byte_count} + (VALUE_W+1)'(1);

        unique case (sec)
            SEC_ID:   need = ID_NEED;
            SEC_HLEN: need = LEN_NEED;
            SEC_PLEN: need = LEN_NEED;
            SEC_HDR:  need = {1'b0, cur.header_length};
            default:  need = {1'b0, cur.payload_length};
        endcase

        last = (count_inc >= need);

        // Little-endian assembly: the first byte lands in the low bits.
        acc = cur.assembled_value
            | ({{(VALUE_W-BYTE_W){1'b0}}, rx_byte} << {cur.byte_count[2:0], 3'b000});

        nxt = cur;
        nxt.phase = sec;
        res.section      = sec;
        res.byte_out     = rx_byte;
        res.section_last = last;
        res.field_value  = '0;
        res.frame_end    = 1'b0;

        if (last)
        begin
            nxt.byte_count = '0;
        end
        else
        begin
            nxt.byte_count = count_inc[VALUE_W-1:0];
        end

        unique case (sec)
            SEC_ID, SEC_HLEN, SEC_PLEN:
            begin
                if (last)
                begin
                    res.field_value     = acc;
                    nxt.assembled_value = '0;
                    if (sec == SEC_ID)
                    begin
                        nxt.phase = SEC_HLEN;
                    end
                    else if (sec == SEC_HLEN)
                    begin
                        nxt.header_length = acc;
                        nxt.phase         = SEC_PLEN;
                    end
                    else
                    begin
                        nxt.payload_length = acc;
                        // Empty sections are skipped; with both empty the frame ends here.
                        if (cur.header_length != '0)
                        begin
                            nxt.phase = SEC_HDR;
                        end
                        else if (acc != '0)
                        begin
                            nxt.phase = SEC_PAY;
                        end
                        else
                        begin
                            nxt.phase     = SEC_ID;
                            res.frame_end = 1'b1;
                        end
                    end
                end
                else
                begin
                    nxt.assembled_value = acc;
                end
            end
            default:
            begin
                if (last)
                begin
                    if (sec == SEC_HDR && cur.payload_length != '0)
                    begin
                        nxt.phase = SEC_PAY;
                    end
                    else
                    begin
                        nxt.phase     = SEC_ID;
                        res.frame_end = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/length_prefixed_frame_parser.sv @@
// An accepted byte is held in the input register, and its tagged result beat is
// registered in the result register, from which it is presented on the result channel.
// Throughput: one byte per cycle, sustained under continuous valid and ready.
// The per-byte path is the 64-bit section count increment and compare in lpfp_step.
// Reset: the parser returns to the start of a request id with all counts and
// lengths cleared, and both the input and result registers are emptied.
module length_prefixed_frame_parser #(
    parameter int unsigned ID_BYTES  = 8,
    parameter int unsigned LEN_BYTES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    lpfp_byte_if.sink      rx,
    lpfp_result_if.source  parsed
);
    import lpfp_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    parse_result_t      res_next;
    parse_result_t      res_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               advance;

    lpfp_step #(
        .ID_BYTES  (ID_BYTES),
        .LEN_BYTES (LEN_BYTES)
    ) u_step (
        .cur     (state_reg),
        .rx_byte (in_byte_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    assign out_free = !out_valid_reg || parsed.ready;
    assign advance  = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.phase           <= SEC_ID;
            state_reg.byte_count      <= '0;
            state_reg.assembled_value <= '0;
            state_reg.header_length   <= '0;
            state_reg.payload_length  <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign parsed.valid        = out_valid_reg;
    assign parsed.section      = res_reg.section;
    assign parsed.byte_out     = res_reg.byte_out;
    assign parsed.section_last = res_reg.section_last;
    assign parsed.field_value  = res_reg.field_value;
    assign parsed.frame_end    = res_reg.frame_end;

endmodule
